// ----- hdl/mau_pkg.sv -----
// ----------------------------------------------------------------------------
// mau_pkg
// types and constants shared by the modular arithmetic unit
// ----------------------------------------------------------------------------
package mau_pkg;

   localparam int unsigned SV_W     = 64;   // width of the signed value field
   localparam int unsigned CNT_W    = 7;    // step counter, holds up to 64
   localparam int unsigned OP_W     = 4;
   localparam longint unsigned MOD_RESET = 64'd1000000007;

   // operation codes carried on req_tuser
   localparam logic [OP_W-1:0] OP_ADD = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV = 4'd3;
   localparam logic [OP_W-1:0] OP_NEG = 4'd4;
   localparam logic [OP_W-1:0] OP_INV = 4'd5;
   localparam logic [OP_W-1:0] OP_POW = 4'd6;
   localparam logic [OP_W-1:0] OP_EQU = 4'd7;
   localparam logic [OP_W-1:0] OP_RED = 4'd8;

   typedef enum logic [1:0] {
      SEL_A = 2'd0,
      SEL_B = 2'd1,
      SEL_S = 2'd2
   } red_sel_type;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_RED     = 9'b000000010,
      ST_DISP    = 9'b000000100,
      ST_MUL     = 9'b000001000,
      ST_EUC_CHK = 9'b000010000,
      ST_EUC_DIV = 9'b000100000,
      ST_EUC_UPD = 9'b001000000,
      ST_POW     = 9'b010000000,
      ST_FIN     = 9'b100000000
   } state_type;

endpackage

// ----- hdl/modular_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// modular alu: add, sub, mul, div, neg, inverse, pow, equal, signed reduce
// ----------------------------------------------------------------------------
// one beat at a time; a shared add/compare/subtract unit and a subtractor for m minus an operand do the work.
// operands are first reduced by the modulus; mul is a shift-and-add product, inverse runs
// euclid rounds, div is the inverse of the divisor times the dividend, and pow walks
// every exponent bit msb first, square then multiply.
// reset is synchronous; it loads the modulus with 1000000007 and goes idle.
module modular_arithmetic_unit #(
   parameter int unsigned MOD_WIDTH = 31,
   parameter int unsigned EXP_WIDTH = 64,
   localparam int unsigned REQ_BITS = 2*MOD_WIDTH + EXP_WIDTH + mau_pkg::SV_W,
   localparam int unsigned REQ_W    = ((REQ_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_W    = ((MOD_WIDTH + 2 + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // config
   input  logic                      csr_wr_en,
   input  logic [MOD_WIDTH-1:0]      csr_wr_data,   // modulus
   // request
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_W-1:0]          req_tdata,     // operand_a, operand_b, exponent,
                                                    // signed_value, zero pad
   input  logic [mau_pkg::OP_W-1:0]  req_tuser,     // req_type
   // response
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata      // result, is_equal, operand_error,
                                                    // zero pad
);

   localparam int unsigned W  = MOD_WIDTH;
   localparam int unsigned SW = mau_pkg::SV_W;
   localparam int unsigned CW = mau_pkg::CNT_W;

   mau_pkg::state_type   state_ff, state_in;
   mau_pkg::red_sel_type sel_ff, sel_in;

   logic [W-1:0]            m_ff, m_in;
   logic [mau_pkg::OP_W-1:0] op_ff, op_in;
   logic [W-1:0]            a_ff, a_in, b_ff, b_in;
   logic [EXP_WIDTH-1:0]    k_ff, k_in;
   logic [CW-1:0]           kcnt_ff, kcnt_in;
   logic [SW-1:0]           sv_ff, sv_in;
   logic                    sneg_ff, sneg_in;
   logic                    err_ff, err_in;
   logic [SW-1:0]           sh_ff, sh_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [1:0]              ph_ff, ph_in;
   logic [W-1:0]            acc_ff, acc_in;
   logic [W-1:0]            mc_ff, mc_in, mp_ff, mp_in;
   logic [W-1:0]            r_ff, r_in;
   logic                    pwm_ff, pwm_in;
   logic [W-1:0]            x_ff, x_in, y_ff, y_in, u_ff, u_in, v_ff, v_in;
   logic [W-1:0]            rem_ff, rem_in;
   logic                    q_ff, q_in;
   logic [W-1:0]            res_ff, res_in;
   logic                    eq_ff, eq_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]            rsp_res_ff, rsp_res_in;
   logic                    rsp_eq_ff, rsp_eq_in, rsp_err_ff, rsp_err_in;

   // shared unit: out = (x + y + c) reduced once by d
   logic [W-1:0] u_x, u_y, u_d, u_out;
   logic         u_c, u_ge;
   logic [W:0]   u_sum;

   // m minus an operand
   logic [W-1:0] mm_sel, mm_out;

   logic [W-1:0]         in_a, in_b;
   logic [EXP_WIDTH-1:0] in_k;
   logic [SW-1:0]        in_sv;
   logic                 bad_a, bad_b;

   assign in_a  = req_tdata[W-1:0];
   assign in_b  = req_tdata[2*W-1:W];
   assign in_k  = req_tdata[2*W+EXP_WIDTH-1:2*W];
   assign in_sv = req_tdata[2*W+EXP_WIDTH+SW-1:2*W+EXP_WIDTH];
   assign bad_a = in_a >= m_ff;
   assign bad_b = in_b >= m_ff;

   assign u_sum = {1'b0, u_x} + {1'b0, u_y} + (W+1)'(u_c);
   assign u_ge  = u_sum >= {1'b0, u_d};
   assign u_out = u_ge ? W'(u_sum - {1'b0, u_d}) : W'(u_sum);
   assign mm_out = m_ff - mm_sel;

   assign req_tready = (state_ff == mau_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_err_ff, rsp_eq_ff, rsp_res_ff});

   // operand routing into the shared unit
   always_comb begin
      u_x = acc_ff;
      u_y = acc_ff;
      u_c = 1'b0;
      u_d = m_ff;
      mm_sel = acc_ff;
      unique case (state_ff)
         mau_pkg::ST_RED: begin
            u_c = sh_ff[SW-1];
         end
         mau_pkg::ST_MUL: begin
            if (ph_ff[0]) begin
               u_y = mp_ff[W-1] ? mc_ff : '0;
            end
         end
         mau_pkg::ST_EUC_DIV: begin
            unique case (ph_ff)
               2'd0: begin
                  u_x = rem_ff;
                  u_y = rem_ff;
                  u_c = sh_ff[SW-1];
                  u_d = y_ff;
               end
               2'd2: u_y = q_ff ? v_ff : '0;
               default: ;
            endcase
         end
         mau_pkg::ST_EUC_UPD: begin
            mm_sel = acc_ff;
            u_x = u_ff;
            u_y = mm_out;
         end
         mau_pkg::ST_DISP: begin
            u_x = a_ff;
            priority case (op_ff)
               mau_pkg::OP_SUB: begin
                  mm_sel = b_ff;
                  u_y = mm_out;
               end
               mau_pkg::OP_NEG: mm_sel = a_ff;
               mau_pkg::OP_RED: mm_sel = acc_ff;
               default: u_y = b_ff;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;  sel_in = sel_ff;   m_in = m_ff;     op_in = op_ff;
      a_in = a_ff;          b_in = b_ff;       k_in = k_ff;     kcnt_in = kcnt_ff;
      sv_in = sv_ff;        sneg_in = sneg_ff; err_in = err_ff; sh_in = sh_ff;
      cnt_in = cnt_ff;      ph_in = ph_ff;     acc_in = acc_ff; mc_in = mc_ff;
      mp_in = mp_ff;        r_in = r_ff;       pwm_in = pwm_ff; x_in = x_ff;
      y_in = y_ff;          u_in = u_ff;       v_in = v_ff;     rem_in = rem_ff;
      q_in = q_ff;          res_in = res_ff;   eq_in = eq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_res_in = rsp_res_ff; rsp_eq_in = rsp_eq_ff; rsp_err_in = rsp_err_ff;

      if (csr_wr_en) begin
         m_in = csr_wr_data;
      end

      unique case (state_ff)
         mau_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in  = req_tuser;
               k_in   = in_k;
               sneg_in = in_sv[SW-1];
               sv_in  = in_sv[SW-1] ? SW'(-in_sv) : in_sv;
               res_in = '0;
               eq_in  = 1'b0;
               priority if (m_ff < W'(2)) begin
                  err_in   = 1'b1;
                  state_in = mau_pkg::ST_FIN;
               end else if (req_tuser > mau_pkg::OP_RED) begin
                  err_in   = 1'b0;
                  state_in = mau_pkg::ST_FIN;
               end else begin
                  priority if (req_tuser == mau_pkg::OP_RED) begin
                     err_in = 1'b0;
                  end else if (req_tuser == mau_pkg::OP_NEG || req_tuser == mau_pkg::OP_INV
                               || req_tuser == mau_pkg::OP_POW) begin
                     err_in = bad_a;
                  end else begin
                     err_in = bad_a || bad_b;
                  end
                  a_in     = in_a;
                  b_in     = in_b;
                  sh_in    = SW'(in_a) << (SW - W);
                  cnt_in   = CW'(W);
                  acc_in   = '0;
                  sel_in   = mau_pkg::SEL_A;
                  state_in = mau_pkg::ST_RED;
               end
            end
         end

         // msb-first remainder by the modulus
         mau_pkg::ST_RED: begin
            acc_in = u_out;
            sh_in  = {sh_ff[SW-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               acc_in = '0;
               unique case (sel_ff)
                  mau_pkg::SEL_A: begin
                     a_in   = u_out;
                     sh_in  = SW'(b_ff) << (SW - W);
                     cnt_in = CW'(W);
                     sel_in = mau_pkg::SEL_B;
                  end
                  mau_pkg::SEL_B: begin
                     b_in = u_out;
                     if (op_ff == mau_pkg::OP_RED) begin
                        sh_in  = sv_ff;
                        cnt_in = CW'(SW);
                        sel_in = mau_pkg::SEL_S;
                     end else begin
                        state_in = mau_pkg::ST_DISP;
                     end
                  end
                  default: begin
                     acc_in   = u_out;
                     state_in = mau_pkg::ST_DISP;
                  end
               endcase
            end
         end

         mau_pkg::ST_DISP: begin
            state_in = mau_pkg::ST_FIN;
            unique case (op_ff)
               mau_pkg::OP_ADD, mau_pkg::OP_SUB: res_in = u_out;
               mau_pkg::OP_NEG: res_in = (a_ff == '0) ? '0 : mm_out;
               mau_pkg::OP_EQU: eq_in = (a_ff == b_ff);
               mau_pkg::OP_RED: res_in = (sneg_ff && acc_ff != '0) ? mm_out : acc_ff;
               mau_pkg::OP_MUL: begin
                  mc_in = a_ff;  mp_in = b_ff;  acc_in = '0;
                  cnt_in = CW'(W);  ph_in = 2'd0;
                  state_in = mau_pkg::ST_MUL;
               end
               mau_pkg::OP_DIV, mau_pkg::OP_INV: begin
                  x_in = (op_ff == mau_pkg::OP_DIV) ? b_ff : a_ff;
                  y_in = m_ff;
                  u_in = W'(1);
                  v_in = '0;
                  state_in = mau_pkg::ST_EUC_CHK;
               end
               mau_pkg::OP_POW: begin
                  r_in = W'(1);
                  kcnt_in = CW'(EXP_WIDTH);
                  state_in = mau_pkg::ST_POW;
               end
               default: ;
            endcase
         end

         // horner product: double, then add multiplicand on a set bit
         mau_pkg::ST_MUL: begin
            acc_in = u_out;
            ph_in  = {1'b0, ~ph_ff[0]};
            if (ph_ff[0]) begin
               mp_in  = {mp_ff[W-2:0], 1'b0};
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  if (op_ff == mau_pkg::OP_POW) begin
                     r_in = u_out;
                     if (!pwm_ff && k_ff[EXP_WIDTH-1]) begin
                        mc_in = u_out;  mp_in = a_ff;  acc_in = '0;
                        cnt_in = CW'(W);  ph_in = 2'd0;  pwm_in = 1'b1;
                     end else begin
                        k_in = k_ff << 1;
                        kcnt_in = kcnt_ff - 1'b1;
                        state_in = mau_pkg::ST_POW;
                     end
                  end else begin
                     res_in = u_out;
                     state_in = mau_pkg::ST_FIN;
                  end
               end
            end
         end

         mau_pkg::ST_POW: begin
            if (kcnt_ff == '0) begin
               res_in = r_ff;
               state_in = mau_pkg::ST_FIN;
            end else begin
               mc_in = r_ff;  mp_in = r_ff;  acc_in = '0;
               cnt_in = CW'(W);  ph_in = 2'd0;  pwm_in = 1'b0;
               state_in = mau_pkg::ST_MUL;
            end
         end

         mau_pkg::ST_EUC_CHK: begin
            if (y_ff == '0) begin
               if (op_ff == mau_pkg::OP_DIV) begin
                  mc_in = a_ff;  mp_in = u_ff;  acc_in = '0;
                  cnt_in = CW'(W);  ph_in = 2'd0;
                  state_in = mau_pkg::ST_MUL;
               end else begin
                  res_in = u_ff;
                  state_in = mau_pkg::ST_FIN;
               end
            end else begin
               sh_in  = SW'(x_ff) << (SW - W);
               rem_in = '0;
               acc_in = '0;
               cnt_in = CW'(W);
               ph_in  = 2'd0;
               state_in = mau_pkg::ST_EUC_DIV;
            end
         end

         // quotient bit by bit; acc collects quotient times v modulo m
         mau_pkg::ST_EUC_DIV: begin
            unique case (ph_ff)
               2'd0: begin
                  rem_in = u_out;
                  q_in   = u_ge;
                  sh_in  = {sh_ff[SW-2:0], 1'b0};
                  ph_in  = 2'd1;
               end
               2'd1: begin
                  acc_in = u_out;
                  ph_in  = 2'd2;
               end
               default: begin
                  acc_in = u_out;
                  ph_in  = 2'd0;
                  cnt_in = cnt_ff - 1'b1;
                  if (cnt_ff == CW'(1)) begin
                     state_in = mau_pkg::ST_EUC_UPD;
                  end
               end
            endcase
         end

         mau_pkg::ST_EUC_UPD: begin
            x_in = y_ff;
            y_in = rem_ff;
            u_in = v_ff;
            v_in = u_out;
            state_in = mau_pkg::ST_EUC_CHK;
         end

         mau_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in = res_ff;
               rsp_eq_in  = eq_ff;
               rsp_err_in = err_ff;
               state_in   = mau_pkg::ST_IDLE;
            end
         end

         default: state_in = mau_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mau_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         m_ff         <= W'(mau_pkg::MOD_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         m_ff         <= m_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;   op_ff <= op_in;     a_ff <= a_in;       b_ff <= b_in;
      k_ff <= k_in;       kcnt_ff <= kcnt_in; sv_ff <= sv_in;     sneg_ff <= sneg_in;
      err_ff <= err_in;   sh_ff <= sh_in;     cnt_ff <= cnt_in;   ph_ff <= ph_in;
      acc_ff <= acc_in;   mc_ff <= mc_in;     mp_ff <= mp_in;     r_ff <= r_in;
      pwm_ff <= pwm_in;   x_ff <= x_in;       y_ff <= y_in;       u_ff <= u_in;
      v_ff <= v_in;       rem_ff <= rem_in;   q_ff <= q_in;       res_ff <= res_in;
      eq_ff <= eq_in;     rsp_res_ff <= rsp_res_in;
      rsp_eq_ff <= rsp_eq_in;  rsp_err_ff <= rsp_err_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accepted a beat but stayed ready");

   a_mul_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mau_pkg::ST_MUL) |-> (acc_ff < m_ff))
      else $error("product accumulator not below modulus");

   a_euc_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mau_pkg::ST_EUC_DIV) |-> (rem_ff < y_ff))
      else $error("euclid remainder not below divisor");

   a_equal_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_eq_ff) |-> (rsp_res_ff == '0))
      else $error("equal beat carries a nonzero result");

endmodule

// ----- test/mau_checker.sv -----
// ----------------------------------------------------------------------------
// mau_checker
// watches the modulus writes and both streams of the modular arithmetic unit,
// works out the residue due for every accepted request and compares each
// response beat against the oldest one still outstanding
// ----------------------------------------------------------------------------
module mau_checker #(
   parameter int unsigned MW    = 31,
   parameter int unsigned EW    = 64,
   parameter int unsigned REQ_W = 192,
   parameter int unsigned RSP_W = 40
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [MW-1:0]            csr_wr_data,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_W-1:0]         req_tdata,
   input  logic [mau_pkg::OP_W-1:0] req_tuser,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_W-1:0]         rsp_tdata,
   output int                       fail_count,
   output int                       outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // packed from the top bit down, so residue lands in the low bits as on the bus
   typedef struct packed {
      logic          operand_error;
      logic          is_equal;
      logic [MW-1:0] residue;
   } mau_result_type;

   mau_result_type   residues_due[$];
   logic [MW-1:0]    modulus;
   int               beat_no;

   function automatic longint unsigned mod_inverse(longint unsigned a, longint unsigned m);
      longint x, y, u, v, t, q;
      x = a; y = m; u = 1; v = 0;
      while (y != 0) begin
         q = x / y;
         x = x - q * y;
         t = x; x = y; y = t;
         u = u - q * v;
         t = u; u = v; v = t;
      end
      u = u % longint'(m);
      if (u < 0) u = u + longint'(m);
      return longint'(u);
   endfunction

   function automatic longint unsigned mod_power(longint unsigned a, logic [EW-1:0] k,
                                                 longint unsigned m);
      longint unsigned r;
      r = 1 % m;
      while (k != 0) begin
         if (k[0]) r = (r * a) % m;
         a = (a * a) % m;
         k = k >> 1;
      end
      return r;
   endfunction

   function automatic mau_result_type modular_result(logic [mau_pkg::OP_W-1:0] op,
         logic [MW-1:0] a_in, logic [MW-1:0] b_in, logic [EW-1:0] k, logic [63:0] sv_in,
         logic [MW-1:0] m_in);
      mau_result_type   r;
      longint unsigned  m, a, b, res;
      longint           s;
      logic             bad_a, bad_b;
      r = '0;
      m = m_in; a = a_in; b = b_in; res = 0;
      // degenerate modulus flags every request
      if (m < 2) begin
         r.operand_error = 1'b1;
         return r;
      end
      bad_a = a >= m;
      bad_b = b >= m;
      a = a % m;
      b = b % m;
      case (op)
         mau_pkg::OP_ADD: begin res = (a + b) % m; r.operand_error = bad_a | bad_b; end
         mau_pkg::OP_SUB: begin res = (a + m - b) % m; r.operand_error = bad_a | bad_b; end
         mau_pkg::OP_MUL: begin res = (a * b) % m; r.operand_error = bad_a | bad_b; end
         mau_pkg::OP_DIV: begin
            res = (a * mod_inverse(b, m)) % m;
            r.operand_error = bad_a | bad_b;
         end
         mau_pkg::OP_NEG: begin res = (a == 0) ? 0 : m - a; r.operand_error = bad_a; end
         mau_pkg::OP_INV: begin res = mod_inverse(a, m); r.operand_error = bad_a; end
         mau_pkg::OP_POW: begin res = mod_power(a, k, m); r.operand_error = bad_a; end
         mau_pkg::OP_EQU: begin r.is_equal = (a == b); r.operand_error = bad_a | bad_b; end
         mau_pkg::OP_RED: begin
            s = sv_in;
            s = s % longint'(m);
            if (s < 0) s = s + longint'(m);
            res = s;
         end
         default: ;
      endcase
      r.residue = res[MW-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("%0t mismatch beat %0d %s: got %0d want %0d", $realtime, beat_no, what, got,
               want);
      fail_count++;
   endtask

   initial begin
      fail_count  = 0;
      outstanding = 0;
      beat_no     = 0;
      modulus     = MW'(mau_pkg::MOD_RESET);
   end

   always @(posedge clock) begin
      mau_result_type want, got;
      if (reset) begin
         modulus = MW'(mau_pkg::MOD_RESET);
      end else begin
         if (csr_wr_en) modulus = csr_wr_data;
         if (req_tvalid && req_tready)
            residues_due.push_back(modular_result(req_tuser, req_tdata[MW-1:0],
               req_tdata[2*MW-1:MW], req_tdata[2*MW+EW-1:2*MW],
               req_tdata[2*MW+EW+63:2*MW+EW], modulus));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[MW+1:0];
            if (residues_due.size() == 0) begin
               report_mismatch("beat with nothing outstanding", got.residue, 0);
            end else begin
               want = residues_due.pop_front();
               if (got.residue != want.residue)
                  report_mismatch("result", got.residue, want.residue);
               if (got.is_equal != want.is_equal)
                  report_mismatch("is_equal", got.is_equal, want.is_equal);
               if (got.operand_error != want.operand_error)
                  report_mismatch("operand_error", got.operand_error, want.operand_error);
            end
            beat_no++;
         end
      end
      outstanding = residues_due.size();
   end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// regression for the modular arithmetic unit: directed corner requests, then
// random requests under several moduli, with random gaps on both streams
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MW    = 31;
   localparam int unsigned EW    = 64;
   localparam int unsigned REQ_W = 192;
   localparam int unsigned RSP_W = 40;
   localparam int unsigned OP_W  = mau_pkg::OP_W;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic [MW-1:0]    csr_wr_data = '0;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata   = '0;
   logic [OP_W-1:0]  req_tuser   = '0;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   int               fail_count, outstanding;
   bit               quiet;
   logic [MW-1:0]    cur_mod;

   always #6 clock = ~clock;

   modular_arithmetic_unit #(.MOD_WIDTH(MW), .EXP_WIDTH(EW)) dut (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   mau_checker #(.MW(MW), .EW(EW), .REQ_W(REQ_W), .RSP_W(RSP_W)) chk (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .fail_count, .outstanding
   );

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side back-pressure
   initial begin
      int g;
      @(negedge reset);
      forever begin
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic send_request(logic [OP_W-1:0] op, logic [MW-1:0] a, logic [MW-1:0] b,
                               logic [EW-1:0] k, logic [63:0] sv);
      int g;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_W-2*MW-EW-64){1'b0}}, sv, k, b, a};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic set_modulus(logic [MW-1:0] m);
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_mod = m;
   endtask

   function automatic logic [MW-1:0] pick_operand(logic [MW-1:0] m);
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return MW'($urandom % m);
      if (r < 83) return m - 1;
      if (r < 88) return '0;
      return MW'($urandom);                 // often not below the modulus
   endfunction

   task automatic random_request();
      logic [OP_W-1:0] op;
      logic [EW-1:0]   k;
      logic [63:0]     sv;
      int              r;
      r  = $urandom_range(0, 99);
      op = (r < 95) ? OP_W'($urandom_range(0, 8)) : OP_W'($urandom_range(9, 15));
      // mostly small exponents, a few full width
      k  = ($urandom_range(0, 99) < 85) ? EW'($urandom_range(0, 255)) : {$urandom, $urandom};
      r  = $urandom_range(0, 3);
      case (r)
         0: sv = {$urandom, $urandom};
         1: sv = -64'(longint'(cur_mod) * $urandom_range(1, 1000));
         2: sv = 64'(longint'($urandom_range(0, 2000)) - 1000);
         default: sv = -64'({$urandom, $urandom} >> 1);
      endcase
      send_request(op, pick_operand(cur_mod), pick_operand(cur_mod), k, sv);
   endtask

   initial begin
      logic [MW-1:0] moduli[7];
      moduli = '{31'd2, 31'h7fffffff, 31'd1000, 31'd97, 31'd65536, 31'd3, 31'd1000000007};
      cur_mod = 31'd1000000007;
      quiet = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners under the reset modulus
      send_request(mau_pkg::OP_ADD, cur_mod - 1, cur_mod - 1, 0, 0);
      send_request(mau_pkg::OP_SUB, 0, 1, 0, 0);
      send_request(mau_pkg::OP_MUL, cur_mod - 1, cur_mod - 1, 0, 0);
      send_request(mau_pkg::OP_DIV, 5, 0, 0, 0);
      send_request(mau_pkg::OP_DIV, 6, 3, 0, 0);
      send_request(mau_pkg::OP_NEG, 0, 0, 0, 0);
      send_request(mau_pkg::OP_NEG, 1, 0, 0, 0);
      send_request(mau_pkg::OP_INV, 0, 0, 0, 0);
      send_request(mau_pkg::OP_INV, 2, 0, 0, 0);
      send_request(mau_pkg::OP_POW, 3, 0, 0, 0);
      send_request(mau_pkg::OP_POW, cur_mod - 1, 0, '1, 0);
      send_request(mau_pkg::OP_POW, 2, 0, 64'h8000000000000001, 0);
      send_request(mau_pkg::OP_EQU, 7, 7, 0, 0);
      send_request(mau_pkg::OP_EQU, 7, 8, 0, 0);
      send_request(mau_pkg::OP_RED, 0, 0, 0, 64'h8000000000000000);
      send_request(mau_pkg::OP_RED, 0, 0, 0, 64'h7fffffffffffffff);
      send_request(mau_pkg::OP_RED, 0, 0, 0, -64'(longint'(cur_mod) * 3));
      send_request(mau_pkg::OP_ADD, '1, cur_mod, 0, 0);     // operands not below the modulus
      send_request(mau_pkg::OP_INV, '1, 0, 0, 0);
      send_request(OP_W'(9), 1, 1, 0, 0);
      send_request(OP_W'(15), '1, '1, '1, '1);

      // inverse of and division by operands sharing a factor with the modulus
      set_modulus(31'd1000);
      send_request(mau_pkg::OP_INV, 10, 0, 0, 0);
      send_request(mau_pkg::OP_DIV, 7, 250, 0, 0);

      for (int p = 0; p < 8; p++) begin
         if (p > 0) set_modulus(p < 8 ? ((p == 7) ? 31'($urandom_range(2, 31'h7fffffff))
                                                  : moduli[p-1]) : cur_mod);
         quiet = (p == 3);
         repeat (100) random_request();
      end

      if (req_tvalid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      while (outstanding != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #500ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/mau_pkg.sv
hdl/modular_arithmetic_unit.sv
test/mau_checker.sv
test/tb.sv
